// ===== hdl/wlg_pkg.sv =====
// shared constants, codes and state type of the waypoint lookahead guidance core
package wlg_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int NUM_AXES  = 3;
    localparam int AX_W      = 2;
    localparam int MAX_WP    = 16;
    localparam int WP_IDX_W  = $clog2(MAX_WP);
    localparam int CNT_W     = WP_IDX_W + 1;
    localparam int REG_W     = 31;
    localparam int QUAT_W    = 15;
    localparam int QUATZ_W   = QUAT_W + 1;

    // arithmetic unit widths
    localparam int MAG_W     = COORD_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int DIV_N_W   = PROD_W;
    localparam int DIV_D_W   = ROOT_W;
    localparam int HALF_SHIFT = 29;

    // stream widths
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 232;
    localparam int CFG_IDX_W = 3;

    // input item kinds
    localparam logic [S_TUSER_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [S_TUSER_W-1:0] MODE_POS  = 2'd1;
    localparam logic [S_TUSER_W-1:0] MODE_TICK = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_AT_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT = 3'd4;

    // register reset values
    localparam logic [REG_W-1:0] ACCEPT_RST = 31'd32768;
    localparam logic [REG_W-1:0] LOOK_RST   = 31'd98304;
    localparam logic [REG_W-1:0] CRUISE_RST = 31'd65536;
    localparam logic [CNT_W-1:0] COUNT_RST  = 5'd1;

    // tick sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_RT_GO,
        ST_RT_WAIT,
        ST_ADV,
        ST_ZERO,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_HDIFF,
        ST_HNORM,
        ST_HSQ_GO,
        ST_HSQ_WAIT,
        ST_HRT_GO,
        ST_HRT_WAIT,
        ST_HDIV_GO,
        ST_HDIV_WAIT,
        ST_HQ_GO,
        ST_HQ_WAIT,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/wlg_mul.sv =====
// bit-serial unsigned shift-add multiplier
module wlg_mul import wlg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  op_a,
    input  logic [MAG_W-1:0]  op_b,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    localparam int MCNT_W = $clog2(MAG_W);

    logic [MAG_W-1:0]  a_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MAG_W:0]    acc_sum;
    logic [MCNT_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;

    // one multiplier bit per cycle, accumulate into the upper half
    always_comb begin
        acc_sum   = {1'b0, prod_reg[PROD_W-1:MAG_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        prod_next = {acc_sum, prod_reg[MAG_W-1:1]};
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MCNT_W'(MAG_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // operand and product shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= op_a;
            prod_reg <= {{MAG_W{1'b0}}, op_b};
        end else if (busy_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== hdl/wlg_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module wlg_div import wlg_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] op_n,
    input  logic [DIV_D_W-1:0] op_d,
    output logic               done,
    output logic [DIV_N_W-1:0] quot
);

    localparam int DCNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] n_reg, n_next;
    logic [DIV_D_W-1:0] d_reg;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W:0]   rem_sh;
    logic               ge;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               busy_reg, done_reg;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        rem_sh   = {rem_reg, n_reg[DIV_N_W-1]};
        ge       = rem_sh >= {1'b0, d_reg};
        rem_next = ge ? DIV_D_W'(rem_sh - {1'b0, d_reg}) : rem_sh[DIV_D_W-1:0];
        n_next   = {n_reg[DIV_N_W-2:0], ge};
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_N_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // dividend/quotient shift register and partial remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= op_n;
            d_reg   <= op_d;
            rem_reg <= '0;
        end else if (busy_reg) begin
            n_reg   <= n_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = n_reg;

endmodule

// ===== hdl/wlg_sqrt.sv =====
// digit-serial integer square root, two radicand bits per cycle
module wlg_sqrt import wlg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  op_rad,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W  = ROOT_W + 2;
    localparam int SCNT_W = $clog2(ROOT_W);

    logic [SUM_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W+1:0]  rem_sh, trial;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              ge;
    logic [SCNT_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;

    // bring down two bits, try root*4+1
    always_comb begin
        rem_sh    = {rem_reg, rad_reg[SUM_W-1:SUM_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = rem_sh >= trial;
        rem_next  = ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        root_next = {root_reg[ROOT_W-2:0], ge};
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SCNT_W'(ROOT_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // radicand shift register, remainder and root
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= op_rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/waypoint_lookahead_guidance_core.sv =====
// Lookahead waypoint follower: load and position items give no result, nor does a tick
// before any position. A guidance tick with a known position runs a sequencer over one
// bit-serial multiplier, one bit-serial divider and one two-bit-per-cycle square root:
// three squares, one root, six multiply/divide pairs for setpoint and velocity, a
// normalizing shift, two squares, one root and two divide/root pairs for the heading.
// A tick at zero distance skips the six pairs, and one that reaches the last waypoint
// without hold gives no result. Items are taken only while no tick is in progress; a
// finished result waits in the output register while new items are taken, and a tick
// that finishes while that register is still full waits for it to drain.
module waypoint_lookahead_guidance_core import wlg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // slot, coord_x, coord_y, coord_z from bit 0 up
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // set_x, set_y, set_z, feed_vx, feed_vy, feed_vz, quat_w, quat_z, active_index
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]      cfg_data
);

    state_t state_reg, state_next;

    // configuration
    logic [REG_W-1:0] accept_reg, look_reg, cruise_reg;
    logic             hold_reg;
    logic [CNT_W-1:0] count_reg;

    // block state
    logic signed [COORD_W-1:0] wp_reg [MAX_WP][NUM_AXES];
    logic signed [COORD_W-1:0] pos_reg [NUM_AXES];
    logic                      known_reg;
    logic [WP_IDX_W-1:0]       tgt_reg;

    // tick scratch
    logic [MAG_W-1:0]          mag_reg [NUM_AXES];
    logic                      neg_reg [NUM_AXES];
    logic [SUM_W-1:0]          sum_reg;
    logic [ROOT_W-1:0]         dist_reg;
    logic [REG_W-1:0]          step_reg;
    logic [AX_W-1:0]           ax_reg;
    logic                      kind_reg;
    logic signed [COORD_W-1:0] set_reg [NUM_AXES];
    logic signed [COORD_W-1:0] vel_reg [NUM_AXES];
    logic [MAG_W-1:0]          hx_reg, hy_reg;
    logic                      exneg_reg, eyneg_reg;
    logic [MAG_W-1:0]          r_reg;
    logic [QUAT_W-1:0]         qw_reg, qz_reg;
    logic [M_TDATA_W-1:0]      out_data_reg;
    logic                      out_valid_reg;

    // arithmetic unit hookup
    logic               mul_start, div_start, sqrt_start;
    logic [MAG_W-1:0]   mul_a, mul_b;
    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic [SUM_W-1:0]   sqrt_rad;
    logic               mul_done, div_done, sqrt_done;
    logic [PROD_W-1:0]  mul_prod;
    logic [DIV_N_W-1:0] div_quot;
    logic [ROOT_W-1:0]  sqrt_root;

    // input fields
    logic [WP_IDX_W-1:0]       in_slot;
    logic signed [COORD_W-1:0] in_coord [NUM_AXES];
    logic                      s_fire, out_load;

    assign in_slot     = s_tdata[3:0];
    assign in_coord[0] = s_tdata[35:4];
    assign in_coord[1] = s_tdata[67:36];
    assign in_coord[2] = s_tdata[99:68];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // waypoint count limits and target clamp
    logic [CNT_W-1:0]    n_eff;
    logic [WP_IDX_W-1:0] tgt_clamped;
    logic                has_next, reached;

    always_comb begin
        if (count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (count_reg > CNT_W'(MAX_WP)) begin
            n_eff = CNT_W'(MAX_WP);
        end else begin
            n_eff = count_reg;
        end
        tgt_clamped = ({1'b0, tgt_reg} >= n_eff) ? WP_IDX_W'(n_eff - 1'b1) : tgt_reg;
        has_next    = ({1'b0, tgt_reg} + CNT_W'(1)) < n_eff;
        reached     = dist_reg < {2'b00, accept_reg};
    end

    // offsets from vehicle to active waypoint
    logic signed [COORD_W:0] diff [NUM_AXES];
    logic [COORD_W:0]        diff_abs [NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            diff[i]     = {wp_reg[tgt_reg][i][COORD_W-1], wp_reg[tgt_reg][i]}
                        - {pos_reg[i][COORD_W-1], pos_reg[i]};
            diff_abs[i] = diff[i][COORD_W] ? -diff[i] : diff[i];
        end
    end

    // setpoint clamp and velocity saturation for the current axis
    logic signed [COORD_W+1:0] set_sum;
    logic [MAG_W+1:0]          step_ext;
    logic signed [COORD_W-1:0] set_sat, vel_sat;
    logic                      vel_big;

    always_comb begin
        step_ext = {2'b00, div_quot[MAG_W-1:0]};
        set_sum  = {{2{pos_reg[ax_reg][COORD_W-1]}}, pos_reg[ax_reg]}
                 + (neg_reg[ax_reg] ? -step_ext : step_ext);
        if (set_sum[COORD_W+1:COORD_W-1] == 3'b000 || set_sum[COORD_W+1:COORD_W-1] == 3'b111) begin
            set_sat = set_sum[COORD_W-1:0];
        end else if (set_sum[COORD_W+1]) begin
            set_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            set_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
        vel_big = |div_quot[DIV_N_W-1:COORD_W-1];
        if (neg_reg[ax_reg]) begin
            vel_sat = vel_big ? {1'b1, {(COORD_W-1){1'b0}}}
                              : -{1'b0, div_quot[COORD_W-2:0]};
        end else begin
            vel_sat = vel_big ? {1'b0, {(COORD_W-1){1'b1}}}
                              : {1'b0, div_quot[COORD_W-2:0]};
        end
    end

    // heading offset and normalization
    logic signed [COORD_W:0] ex, ey;
    logic [COORD_W:0]        ex_abs, ey_abs;
    logic [MAG_W-1:0]        big;
    logic                    in_range, h_plus;
    logic [MAG_W:0]          half_c;
    logic [QUAT_W-1:0]       q_sat;
    logic [QUATZ_W-1:0]      qz_signed;

    always_comb begin
        ex       = {set_reg[0][COORD_W-1], set_reg[0]} - {pos_reg[0][COORD_W-1], pos_reg[0]};
        ey       = {set_reg[1][COORD_W-1], set_reg[1]} - {pos_reg[1][COORD_W-1], pos_reg[1]};
        ex_abs   = ex[COORD_W] ? -ex : ex;
        ey_abs   = ey[COORD_W] ? -ey : ey;
        big      = (hx_reg > hy_reg) ? hx_reg : hy_reg;
        in_range = !big[MAG_W-1] && big[MAG_W-2];
        h_plus   = !kind_reg ^ exneg_reg;
        half_c   = h_plus ? ({1'b0, r_reg} + {1'b0, hx_reg}) : ({1'b0, r_reg} - {1'b0, hx_reg});
        q_sat    = (|sqrt_root[ROOT_W-1:QUAT_W]) ? {QUAT_W{1'b1}} : sqrt_root[QUAT_W-1:0];
        qz_signed = eyneg_reg ? QUATZ_W'(-{1'b0, qz_reg}) : {1'b0, qz_reg};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == MODE_TICK && known_reg) state_next = ST_DIFF;
            end
            ST_DIFF:     state_next = ST_SQ_GO;
            ST_SQ_GO:    state_next = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (mul_done) state_next = (ax_reg == AX_W'(NUM_AXES - 1)) ? ST_RT_GO : ST_SQ_GO;
            end
            ST_RT_GO:    state_next = ST_RT_WAIT;
            ST_RT_WAIT: begin
                if (sqrt_done) state_next = ST_ADV;
            end
            ST_ADV: begin
                if (reached && !has_next && !hold_reg) begin
                    state_next = ST_IDLE;
                end else if (dist_reg == '0) begin
                    state_next = ST_ZERO;
                end else begin
                    state_next = ST_MUL_GO;
                end
            end
            ST_ZERO:     state_next = ST_HDIFF;
            ST_MUL_GO:   state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) state_next = ST_DIV_GO;
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (ax_reg == AX_W'(NUM_AXES - 1) && kind_reg) ? ST_HDIFF
                                                                            : ST_MUL_GO;
                end
            end
            ST_HDIFF: begin
                state_next = (ex == '0 && ey == '0) ? ST_OUT : ST_HNORM;
            end
            ST_HNORM: begin
                if (in_range) state_next = ST_HSQ_GO;
            end
            ST_HSQ_GO:   state_next = ST_HSQ_WAIT;
            ST_HSQ_WAIT: begin
                if (mul_done) state_next = (ax_reg == AX_W'(1)) ? ST_HRT_GO : ST_HSQ_GO;
            end
            ST_HRT_GO:   state_next = ST_HRT_WAIT;
            ST_HRT_WAIT: begin
                if (sqrt_done) state_next = ST_HDIV_GO;
            end
            ST_HDIV_GO:  state_next = ST_HDIV_WAIT;
            ST_HDIV_WAIT: begin
                if (div_done) state_next = ST_HQ_GO;
            end
            ST_HQ_GO:    state_next = ST_HQ_WAIT;
            ST_HQ_WAIT: begin
                if (sqrt_done) state_next = kind_reg ? ST_OUT : ST_HDIV_GO;
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // unit starts and operand selection
    always_comb begin
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = mag_reg[ax_reg];
        mul_b      = mag_reg[ax_reg];
        div_n      = mul_prod + {{(DIV_N_W-ROOT_W+1){1'b0}}, dist_reg[ROOT_W-1:1]};
        div_d      = dist_reg;
        sqrt_rad   = sum_reg;
        case (state_reg)
            ST_SQ_GO: begin
                mul_start = 1'b1;
            end
            ST_RT_GO: begin
                sqrt_start = 1'b1;
            end
            ST_MUL_GO: begin
                mul_start = 1'b1;
                mul_b     = kind_reg ? {1'b0, cruise_reg} : {1'b0, step_reg};
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
            end
            ST_HSQ_GO: begin
                mul_start = 1'b1;
                mul_a     = (ax_reg == '0) ? hx_reg : hy_reg;
                mul_b     = (ax_reg == '0) ? hx_reg : hy_reg;
            end
            ST_HRT_GO: begin
                sqrt_start = 1'b1;
            end
            ST_HDIV_GO: begin
                div_start = 1'b1;
                div_n     = {2'b00, half_c, {HALF_SHIFT{1'b0}}};
                div_d     = {1'b0, r_reg};
            end
            ST_HQ_GO: begin
                sqrt_start = 1'b1;
                sqrt_rad   = {2'b00, div_quot};
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // control state, configuration and item handling
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            accept_reg    <= ACCEPT_RST;
            look_reg      <= LOOK_RST;
            cruise_reg    <= CRUISE_RST;
            hold_reg      <= 1'b1;
            count_reg     <= COUNT_RST;
            known_reg     <= 1'b0;
            tgt_reg       <= '0;
            ax_reg        <= '0;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) pos_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ACCEPT_RADIUS:  accept_reg <= cfg_data;
                    CFG_LOOKAHEAD_DIST: look_reg   <= cfg_data;
                    CFG_CRUISE_SPEED:   cruise_reg <= cfg_data;
                    CFG_HOLD_AT_END:    hold_reg   <= cfg_data[0];
                    CFG_WAYPOINT_COUNT: count_reg  <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            // position update and tick target clamp
            if (s_fire && s_tuser == MODE_POS) begin
                for (int i = 0; i < NUM_AXES; i++) pos_reg[i] <= in_coord[i];
                known_reg <= 1'b1;
            end
            if (s_fire && s_tuser == MODE_TICK && known_reg) begin
                tgt_reg <= tgt_clamped;
            end
            // waypoint advance
            if (state_reg == ST_ADV && reached && has_next) begin
                tgt_reg <= tgt_reg + 1'b1;
            end
            // loop counters
            case (state_reg)
                ST_SQ_WAIT: begin
                    if (mul_done) begin
                        ax_reg <= (ax_reg == AX_W'(NUM_AXES - 1)) ? '0 : ax_reg + 1'b1;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (kind_reg) begin
                            kind_reg <= 1'b0;
                            ax_reg   <= (ax_reg == AX_W'(NUM_AXES - 1)) ? '0 : ax_reg + 1'b1;
                        end else begin
                            kind_reg <= 1'b1;
                        end
                    end
                end
                ST_HSQ_WAIT: begin
                    if (mul_done) ax_reg <= (ax_reg == AX_W'(1)) ? '0 : ax_reg + 1'b1;
                end
                ST_HQ_WAIT: begin
                    if (sqrt_done) kind_reg <= !kind_reg;
                end
                default: ;
            endcase
            // result register handshake
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // waypoint table writes
    always_ff @(posedge aclk) begin
        if (s_fire && s_tuser == MODE_LOAD) begin
            for (int i = 0; i < NUM_AXES; i++) wp_reg[in_slot][i] <= in_coord[i];
        end
    end

    // tick datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_DIFF: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    mag_reg[i] <= diff_abs[i][MAG_W-1:0];
                    neg_reg[i] <= diff[i][COORD_W];
                end
                sum_reg <= '0;
            end
            ST_SQ_WAIT, ST_HSQ_WAIT: begin
                if (mul_done) sum_reg <= sum_reg + {2'b00, mul_prod};
            end
            ST_RT_WAIT: begin
                if (sqrt_done) dist_reg <= sqrt_root;
            end
            ST_ADV: begin
                step_reg <= ({2'b00, look_reg} < dist_reg) ? look_reg : dist_reg[REG_W-1:0];
            end
            ST_ZERO: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    set_reg[i] <= wp_reg[tgt_reg][i];
                    vel_reg[i] <= '0;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (kind_reg) begin
                        vel_reg[ax_reg] <= vel_sat;
                    end else begin
                        set_reg[ax_reg] <= set_sat;
                    end
                end
            end
            ST_HDIFF: begin
                hx_reg    <= ex_abs[MAG_W-1:0];
                hy_reg    <= ey_abs[MAG_W-1:0];
                exneg_reg <= ex[COORD_W];
                eyneg_reg <= ey[COORD_W];
                qw_reg    <= {QUAT_W{1'b1}};
                qz_reg    <= '0;
                sum_reg   <= '0;
            end
            ST_HNORM: begin
                if (big[MAG_W-1]) begin
                    hx_reg <= {1'b0, hx_reg[MAG_W-1:1]};
                    hy_reg <= {1'b0, hy_reg[MAG_W-1:1]};
                end else if (!big[MAG_W-2]) begin
                    hx_reg <= {hx_reg[MAG_W-2:0], 1'b0};
                    hy_reg <= {hy_reg[MAG_W-2:0], 1'b0};
                end
            end
            ST_HRT_WAIT: begin
                if (sqrt_done) r_reg <= sqrt_root[MAG_W-1:0];
            end
            ST_HQ_WAIT: begin
                if (sqrt_done) begin
                    if (kind_reg) begin
                        qz_reg <= q_sat;
                    end else begin
                        qw_reg <= q_sat;
                    end
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    out_data_reg <= {5'b00000, tgt_reg, qz_signed, qw_reg,
                                     vel_reg[2], vel_reg[1], vel_reg[0],
                                     set_reg[2], set_reg[1], set_reg[0]};
                end
            end
            default: ;
        endcase
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    // shared arithmetic units
    wlg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    wlg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .op_n    (div_n),
        .op_d    (div_d),
        .done    (div_done),
        .quot    (div_quot)
    );

    wlg_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .op_rad  (sqrt_rad),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

`ifndef NO_ASSERTIONS
    // only one arithmetic unit is launched at a time
    a_one_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mul_start, div_start, sqrt_start}))
        else $error("more than one arithmetic unit started");

    // a multiplier completion is only seen while the sequencer waits for it
    a_mul_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_SQ_WAIT || state_reg == ST_MUL_WAIT
                      || state_reg == ST_HSQ_WAIT))
        else $error("multiplier finished outside a wait state");

    // a divider completion is only seen while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT || state_reg == ST_HDIV_WAIT))
        else $error("divider finished outside a wait state");

    // the active waypoint lies inside the table in use once a tick starts
    a_tgt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIFF) |-> ({1'b0, tgt_reg} < n_eff))
        else $error("active waypoint beyond waypoint count");

    // a loaded result is presented on the next cycle
    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("result load did not raise valid");
`endif

endmodule

// ===== tb/sv/guidance_checker.sv =====
// stream monitor, guidance predictor and result comparison for the waypoint lookahead core
`timescale 1ns / 100ps

module guidance_checker import wlg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   result_count
);

    typedef struct {
        logic signed [31:0] sx, sy, sz;
        logic signed [31:0] vx, vy, vz;
        logic [QUAT_W-1:0]  qw;
        logic [QUATZ_W-1:0] qz;
        logic [WP_IDX_W-1:0] idx;
    } setpoint_t;

    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;

    setpoint_t setpoint_q[$];

    // predictor copy of the block state and registers
    longint      wp_tbl[MAX_WP][NUM_AXES];
    longint      veh_pos[NUM_AXES];
    bit          pos_known;
    int unsigned chase_idx;
    logic [REG_W-1:0] accept_r, look_r, cruise_r;
    bit          hold_r;
    logic [CNT_W-1:0] count_r;

    function automatic logic [63:0] root_wide(input logic [127:0] n);
        logic [63:0] res, c;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) res = c;
        end
        return res;
    endfunction

    function automatic logic [63:0] root_narrow(input logic [63:0] n);
        logic [63:0] res, c;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if (c * c <= n) res = c;
        end
        return res;
    endfunction

    // m * num / den rounded to nearest
    function automatic logic [63:0] scale_near(input logic [63:0] m, num, den);
        logic [127:0] t, q;
        t = {64'd0, m} * {64'd0, num} + {64'd0, den >> 1};
        q = t / {64'd0, den};
        return q[63:0];
    endfunction

    function automatic logic [63:0] half_trig(input logic [63:0] c, r);
        logic [63:0] v;
        v = root_narrow((c << HALF_SHIFT) / r);
        return (v > 64'd32767) ? 64'd32767 : v;
    endfunction

    function automatic longint sat32(input longint v);
        return (v < CMIN) ? CMIN : ((v > CMAX) ? CMAX : v);
    endfunction

    // one guidance tick; returns 0 when no setpoint comes out
    function automatic bit guide_tick(output setpoint_t sp);
        int unsigned n;
        longint d[NUM_AXES], setv[NUM_AXES], vel[NUM_AXES];
        logic [63:0] mg[NUM_AXES];
        logic [127:0] sum;
        logic [63:0] range_len, s, mx, my, big, r, qw, qzm;
        longint step, v, ex, ey;
        n = count_r;
        if (n < 1) n = 1;
        if (n > MAX_WP) n = MAX_WP;
        if (chase_idx >= n) chase_idx = n - 1;
        sum = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            d[i] = wp_tbl[chase_idx][i] - veh_pos[i];
            mg[i] = (d[i] < 0) ? -d[i] : d[i];
            sum = sum + {64'd0, mg[i]} * {64'd0, mg[i]};
        end
        range_len = root_wide(sum);
        // waypoint reached: advance, or stop output at the end without hold
        if (range_len < {33'd0, accept_r}) begin
            if (chase_idx + 1 < n) chase_idx++;
            else if (!hold_r) return 0;
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            if (range_len == 0) begin
                setv[i] = wp_tbl[chase_idx][i];
                vel[i] = 0;
            end else begin
                s = ({33'd0, look_r} < range_len) ? {33'd0, look_r} : range_len;
                step = $signed(scale_near(mg[i], s, range_len));
                v = $signed(scale_near(mg[i], {33'd0, cruise_r}, range_len));
                if (d[i] < 0) begin
                    step = -step;
                    v = -v;
                end
                setv[i] = sat32(veh_pos[i] + step);
                vel[i] = sat32(v);
            end
        end
        // heading quaternion from the horizontal step
        ex = setv[0] - veh_pos[0];
        ey = setv[1] - veh_pos[1];
        mx = (ex < 0) ? -ex : ex;
        my = (ey < 0) ? -ey : ey;
        big = (mx > my) ? mx : my;
        if (big == 0) begin
            qw = 64'd32767;
            qzm = 0;
        end else begin
            while (big >= (64'd1 << 31)) begin
                mx >>= 1; my >>= 1; big >>= 1;
            end
            while (big < (64'd1 << 30)) begin
                mx <<= 1; my <<= 1; big <<= 1;
            end
            r = root_narrow(mx * mx + my * my);
            if (ex >= 0) begin
                qw = half_trig(r + mx, r);
                qzm = half_trig(r - mx, r);
            end else begin
                qw = half_trig(r - mx, r);
                qzm = half_trig(r + mx, r);
            end
        end
        sp.sx = setv[0][31:0];
        sp.sy = setv[1][31:0];
        sp.sz = setv[2][31:0];
        sp.vx = vel[0][31:0];
        sp.vy = vel[1][31:0];
        sp.vz = vel[2][31:0];
        sp.qw = qw[QUAT_W-1:0];
        sp.qz = (ey < 0) ? (16'd0 - qzm[15:0]) : qzm[15:0];
        sp.idx = chase_idx[WP_IDX_W-1:0];
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got, exp);
        $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, exp);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        setpoint_t sp, e;
        if (!aresetn) begin
            setpoint_q.delete();
            pos_known = 0;
            chase_idx = 0;
            for (int i = 0; i < NUM_AXES; i++) veh_pos[i] = 0;
            for (int k = 0; k < MAX_WP; k++)
                for (int i = 0; i < NUM_AXES; i++) wp_tbl[k][i] = 0;
            accept_r = ACCEPT_RST;
            look_r = LOOK_RST;
            cruise_r = CRUISE_RST;
            hold_r = 1;
            count_r = COUNT_RST;
        end else begin
            // result transfer against the oldest expected setpoint
            if (m_tvalid && m_tready) begin
                result_count++;
                if (setpoint_q.size() == 0) begin
                    report_mismatch("result with none expected", m_tdata[63:0], 0);
                end else begin
                    e = setpoint_q.pop_front();
                    if (m_tdata[31:0] !== e.sx) report_mismatch("set_x", m_tdata[31:0], e.sx);
                    if (m_tdata[63:32] !== e.sy) report_mismatch("set_y", m_tdata[63:32], e.sy);
                    if (m_tdata[95:64] !== e.sz) report_mismatch("set_z", m_tdata[95:64], e.sz);
                    if (m_tdata[127:96] !== e.vx)
                        report_mismatch("feed_vx", m_tdata[127:96], e.vx);
                    if (m_tdata[159:128] !== e.vy)
                        report_mismatch("feed_vy", m_tdata[159:128], e.vy);
                    if (m_tdata[191:160] !== e.vz)
                        report_mismatch("feed_vz", m_tdata[191:160], e.vz);
                    if (m_tdata[206:192] !== e.qw)
                        report_mismatch("quat_w", m_tdata[206:192], e.qw);
                    if (m_tdata[222:207] !== e.qz)
                        report_mismatch("quat_z", m_tdata[222:207], e.qz);
                    if (m_tdata[226:223] !== e.idx)
                        report_mismatch("active_index", m_tdata[226:223], e.idx);
                end
            end
            // register write transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ACCEPT_RADIUS:  accept_r = cfg_data;
                    CFG_LOOKAHEAD_DIST: look_r = cfg_data;
                    CFG_CRUISE_SPEED:   cruise_r = cfg_data;
                    CFG_HOLD_AT_END:    hold_r = cfg_data[0];
                    CFG_WAYPOINT_COUNT: count_r = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            // input item transfer
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    MODE_LOAD: begin
                        wp_tbl[s_tdata[3:0]][0] = $signed(s_tdata[35:4]);
                        wp_tbl[s_tdata[3:0]][1] = $signed(s_tdata[67:36]);
                        wp_tbl[s_tdata[3:0]][2] = $signed(s_tdata[99:68]);
                    end
                    MODE_POS: begin
                        veh_pos[0] = $signed(s_tdata[35:4]);
                        veh_pos[1] = $signed(s_tdata[67:36]);
                        veh_pos[2] = $signed(s_tdata[99:68]);
                        pos_known = 1;
                    end
                    MODE_TICK: begin
                        if (pos_known && guide_tick(sp))
                            setpoint_q.insert(setpoint_q.size(), sp);
                    end
                    default: ;
                endcase
            end
        end
        pending = setpoint_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// stimulus, clock, reset and verdict for the waypoint lookahead guidance core
`timescale 1ns / 100ps

module tb_top;
    import wlg_pkg::*;

    localparam int DRAIN_CYCLES = 1300;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 190;

    // register index with no register behind it, and the unused item kind
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam logic [S_TUSER_W-1:0] MODE_NONE  = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    int fail_count, pending, result_count;
    bit idle_on;
    int tick_count;
    logic [31:0] tb_wp[MAX_WP][NUM_AXES];
    int cur_count;

    waypoint_lookahead_guidance_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    guidance_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #72_000_000;
        $display("waypoint_lookahead_guidance_core: mismatch");
        $finish;
    end

    // result side backpressure bursts
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready = 0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_tready = aresetn;
        end
    end

    function automatic logic [31:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2 * 1048576) - 1048576;
        if (r < 85) return $urandom;
        if (r < 92) return 32'h7fff_ffff;
        return 32'h8000_0000;
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [3:0] slot,
                             input logic [31:0] x, y, z);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tuser = mode;
        s_tdata = {4'd0, z, y, x, slot};
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (mode == MODE_LOAD) begin
            tb_wp[slot][0] = x; tb_wp[slot][1] = y; tb_wp[slot][2] = z;
        end
        if (mode == MODE_TICK) tick_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    // wait for all setpoints plus one tick time for silent ticks
    task automatic settle();
        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_all(input logic [REG_W-1:0] acc, look, cruise,
                             input bit hold, input logic [CNT_W-1:0] cnt);
        write_reg(CFG_ACCEPT_RADIUS, acc);
        write_reg(CFG_LOOKAHEAD_DIST, look);
        write_reg(CFG_CRUISE_SPEED, cruise);
        write_reg(CFG_HOLD_AT_END, {30'd0, hold});
        write_reg(CFG_WAYPOINT_COUNT, {26'd0, cnt});
        cur_count = (cnt == 0) ? 1 : ((cnt > MAX_WP) ? MAX_WP : cnt);
    endtask

    // one random item, mostly positions near loaded waypoints and ticks
    task automatic random_item();
        int r, k;
        logic [31:0] c[NUM_AXES];
        r = $urandom_range(0, 99);
        k = $urandom_range(0, cur_count - 1);
        if (r < 10) begin
            send_item(MODE_LOAD, 4'($urandom), pick_coord(), pick_coord(), pick_coord());
        end else if (r < 55) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                if (r < 40) c[i] = tb_wp[k][i] + $urandom_range(0, 80000) - 40000;
                else if (r < 46) c[i] = tb_wp[k][i];
                else c[i] = pick_coord();
            end
            send_item(MODE_POS, 4'($urandom), c[0], c[1], c[2]);
        end else if (r < 97) begin
            send_item(MODE_TICK, 4'($urandom), $urandom, $urandom, $urandom);
        end else begin
            send_item(MODE_NONE, 4'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tuser = MODE_LOAD;
        s_tdata = '0;
        cfg_valid = 0;
        cfg_index = CFG_ACCEPT_RADIUS;
        cfg_data = '0;
        idle_on = 1;
        tick_count = 0;
        cur_count = 1;
        repeat (11) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: tick with no position, then fill the whole table
        send_item(MODE_TICK, 4'd0, 0, 0, 0);
        send_item(MODE_LOAD, 4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        for (int k = 1; k < MAX_WP; k++)
            send_item(MODE_LOAD, 4'(k), pick_coord(), pick_coord(), pick_coord());
        // far corner against the most negative waypoint
        send_item(MODE_POS, 4'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(MODE_TICK, 4'd0, 0, 0, 0);
        // exactly on the waypoint
        send_item(MODE_LOAD, 4'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_item(MODE_POS, 4'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_item(MODE_TICK, 4'd0, 0, 0, 0);
        // waypoint straight above: no horizontal offset
        send_item(MODE_POS, 4'd0, 32'h0001_0000, 32'h0002_0000, 32'hfff0_0000);
        send_item(MODE_TICK, 4'd0, 0, 0, 0);
        // heading straight back along negative x
        send_item(MODE_POS, 4'd0, 32'h0050_0000, 32'h0002_0000, 32'h0003_0000);
        send_item(MODE_TICK, 4'd0, 0, 0, 0);
        send_item(MODE_NONE, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        settle();
        write_reg(CFG_NO_REG, 31'h7fff_ffff);

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: write_all(ACCEPT_RST, LOOK_RST, CRUISE_RST, 1, 5'd4);
                1: write_all(31'd0, 31'd0, 31'h7fff_ffff, 0, 5'd16);
                2: write_all(31'h7fff_ffff, 31'h7fff_ffff, 31'd0, 0, 5'd31);
                3: write_all(31'd50000, 31'd200000, 31'd131072, 1, 5'd0);
                default: write_all(REG_W'($urandom_range(0, 200000)),
                                   REG_W'($urandom_range(0, 1 << 21)),
                                   REG_W'($urandom), 1'($urandom_range(0, 1)),
                                   CNT_W'($urandom_range(0, 31)));
            endcase
            if (p == PHASES - 1) idle_on = 0;
            for (int j = 0; j < ITEMS_PER_PHASE; j++) random_item();
        end

        s_tvalid = 0;
        settle();
        $display("covered %0d ticks over %0d register settings, %0d setpoints compared",
                 tick_count, PHASES + 1, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("waypoint_lookahead_guidance_core: match");
        end else begin
            $display("waypoint_lookahead_guidance_core: mismatch");
        end
        $finish;
    end

endmodule
